/* sv/mrfr_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the Modbus RTU frame receiver.
package mrfr_pkg;

   // Largest length byte accepted in read-reply mode (exclusive)
   localparam int unsigned MaxData = 64;

   // Input operation codes
   localparam logic [1:0] OP_ARM  = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Frame status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC_ERR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   // Configuration register indexes
   localparam logic CSR_RX_MODE = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   // CRC constants
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [8:0]  ACK_FRAME_LEN = 9'd8;
   localparam logic [7:0]  ACK_DATA_LEN  = 8'd2;

   // One result word
   typedef struct packed {
      logic [15:0] crc_calc;
      logic [15:0] crc_received;
      logic [7:0]  data_len;
      logic [7:0]  func_code;
      logic [7:0]  dev_addr;
      logic [1:0]  status;
      logic [5:0]  data_index;
      logic [7:0]  data_byte;
      logic        kind;
   } result_type;

   // Modbus CRC-16, one byte, reflected polynomial
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/mrfr_engine.sv */
// Frame parser state, CRC accumulation and result generation for one word per cycle while go is high.
module mrfr_engine import mrfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic        go,
   input  logic [1:0]  op,
   input  logic [7:0]  rx_byte,
   output logic        res_valid,
   output result_type  res
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_READ = 2'd1;
   localparam logic [1:0] PH_ACK  = 2'd2;

   logic        rx_mode_ff;
   logic [15:0] timeout_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [8:0]  frame_total_ff, frame_total_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] idle_ff, idle_in;

   logic [15:0] crc_next;
   logic [9:0]  p_plus2;
   logic [8:0]  data_start;
   logic [8:0]  data_off;
   logic [15:0] crc_rx;
   logic        is_ack;

   assign crc_next   = crc_byte(crc_ff, rx_byte);
   assign p_plus2    = {1'b0, byte_count_ff} + 10'd2;
   assign is_ack     = (phase_ff == PH_ACK);
   assign data_start = is_ack ? 9'd4 : 9'd3;
   assign data_off   = byte_count_ff - data_start;
   assign crc_rx     = {rx_byte, crc_lo_ff};

   // Next state and result for the word at the head of the pipe
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      frame_total_in = frame_total_ff;
      crc_in         = crc_ff;
      addr_in        = addr_ff;
      func_in        = func_ff;
      len_in         = len_ff;
      crc_lo_in      = crc_lo_ff;
      idle_in        = idle_ff;
      res_valid      = 1'b0;
      res            = '0;
      res.kind       = KIND_DONE;

      if (op == OP_ARM) begin
         phase_in       = rx_mode_ff ? PH_ACK : PH_READ;
         byte_count_in  = '0;
         frame_total_in = rx_mode_ff ? ACK_FRAME_LEN : 9'd0;
         crc_in         = CRC_INIT;
         addr_in        = '0;
         func_in        = '0;
         len_in         = rx_mode_ff ? ACK_DATA_LEN : 8'd0;
         crc_lo_in      = '0;
         idle_in        = '0;
      end else if (phase_ff != PH_IDLE && op == OP_TICK) begin
         if ({1'b0, idle_ff} + 17'd1 >= {1'b0, timeout_ff}) begin
            phase_in   = PH_IDLE;
            res_valid  = 1'b1;
            res.status = ST_TIMEOUT;
         end else begin
            idle_in = idle_ff + 16'd1;
         end
      end else if (phase_ff != PH_IDLE && op == OP_BYTE) begin
         idle_in       = '0;
         byte_count_in = byte_count_ff + 9'd1;
         if (byte_count_ff < 9'd2) begin
            // address and function code
            if (byte_count_ff == 9'd0) begin
               addr_in = rx_byte;
            end else begin
               func_in = rx_byte;
            end
            crc_in = crc_next;
         end else if (!is_ack && byte_count_ff == 9'd2) begin
            // length byte
            len_in = rx_byte;
            crc_in = crc_next;
            if ({1'b0, rx_byte} >= 9'(MaxData)) begin
               phase_in   = PH_IDLE;
               res_valid  = 1'b1;
               res.status = ST_OVERFLOW;
            end else begin
               frame_total_in = {1'b0, rx_byte} + 9'd5;
            end
         end else if (p_plus2 < {1'b0, frame_total_ff}) begin
            // payload
            crc_in = crc_next;
            if (byte_count_ff >= data_start) begin
               res_valid      = 1'b1;
               res.kind       = KIND_DATA;
               res.data_byte  = rx_byte;
               res.data_index = data_off[5:0];
            end
         end else if (p_plus2 == {1'b0, frame_total_ff}) begin
            crc_lo_in = rx_byte;
         end else begin
            // CRC high byte closes the frame
            phase_in         = PH_IDLE;
            res_valid        = 1'b1;
            res.status       = (crc_rx == crc_ff) ? ST_OK : ST_CRC_ERR;
            res.crc_received = crc_rx;
            res.crc_calc     = crc_ff;
         end
      end

      res.dev_addr  = addr_ff;
      res.func_code = func_ff;
      res.data_len  = len_ff;
      if (op == OP_BYTE && byte_count_ff == 9'd2 && !is_ack) begin
         res.data_len = rx_byte;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_mode_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RX_MODE: rx_mode_ff <= csr_wdata[0];
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default:     rx_mode_ff <= rx_mode_ff;
         endcase
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_count_ff  <= '0;
         frame_total_ff <= '0;
         crc_ff         <= CRC_INIT;
         addr_ff        <= '0;
         func_ff        <= '0;
         len_ff         <= '0;
         crc_lo_ff      <= '0;
         idle_ff        <= '0;
      end else if (go) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         frame_total_ff <= frame_total_in;
         crc_ff         <= crc_in;
         addr_ff        <= addr_in;
         func_ff        <= func_in;
         len_ff         <= len_in;
         crc_lo_ff      <= crc_lo_in;
         idle_ff        <= idle_in;
      end
   end

endmodule

/* sv/modbus_rtu_frame_receiver.sv */
// Modbus RTU reply receiver top level: input register, parser engine, result register.
//
//   channel | dir | tdata (low bit first)                         | tuser
//   req_    | in  | rx_byte[7:0]                                  | op[1:0]
//   rsp_    | out | data_byte, data_index, status, dev_addr,      | kind
//           |     | func_code, data_len, crc_received, crc_calc   |
//   csr_    | in  | write enable, register index, 16-bit data     | -
//
// One word per cycle sustained while the result side is not stalled.
// Each word is parsed by the engine in the cycle it leaves the input register.
// Reset is synchronous and clears control state, configuration and the parser state.
// A stalled result holds the engine; the input register keeps taking words while it is free.
module modbus_rtu_frame_receiver import mrfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // data_byte[7:0], data_index[13:8], status[15:14],
                                    // dev_addr[23:16], func_code[31:24], data_len[39:32],
                                    // crc_received[55:40], crc_calc[71:56]
   output logic        rsp_tuser,   // kind
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic        in_valid_ff;
   logic [1:0]  in_op_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        out_free;
   logic        go;
   logic        eng_valid;
   result_type  eng_res;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign go         = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || go;

   mrfr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .go        (go),
      .op        (in_op_ff),
      .rx_byte   (in_byte_ff),
      .res_valid (eng_valid),
      .res       (eng_res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= go && eng_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (go && eng_valid) begin
         out_ff <= eng_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {out_ff.crc_calc, out_ff.crc_received, out_ff.data_len,
                        out_ff.func_code, out_ff.dev_addr, out_ff.status,
                        out_ff.data_index, out_ff.data_byte};

endmodule

/* tb/sv/modbus_rtu_frame_receiver_tb.sv */
// Self-checking testbench for the Modbus RTU reply receiver: random frames against a predictor.
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_tb;
   import mrfr_pkg::*;

   // Op code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS = 165;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } rx_word_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [5:0]  data_index;
      logic [1:0]  status;
      logic [7:0]  dev_addr;
      logic [7:0]  func_code;
      logic [7:0]  data_len;
      logic [15:0] crc_received;
      logic [15:0] crc_calc;
   } frame_result_type;

   typedef enum logic [1:0] {LINK_IDLE, LINK_READ, LINK_ACK} link_state_type;
   typedef enum logic [1:0] {FLAW_NONE, FLAW_CRC, FLAW_CUT, FLAW_REARM} frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte[7:0]
   logic [1:0]  req_tuser = OP_ARM;  // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;   // data_byte, data_index, status, dev_addr, func_code,
                             // data_len, crc_received, crc_calc
   logic        rsp_tuser;   // kind
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_RX_MODE;
   logic [15:0] csr_wdata = 16'h0000;

   modbus_rtu_frame_receiver u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stimulus and expectation stores
   rx_word_type      pending_words[$];
   frame_result_type expected_results[$];
   int               words_queued = 0;
   int               words_accepted = 0;
   bit               any_fault = 1'b0;
   bit               src_calm = 1'b0;
   bit               sink_calm = 1'b0;

   // Predictor configuration copy
   logic        mode_ack = 1'b0;
   logic [15:0] tick_limit = TIMEOUT_RESET;

   // Predictor frame state
   link_state_type link_state = LINK_IDLE;
   int          pos_count = 0;
   int          frame_size = 0;
   logic [15:0] crc_acc = CRC_INIT;
   logic [7:0]  got_addr = 8'h00;
   logic [7:0]  got_func = 8'h00;
   logic [7:0]  got_len = 8'h00;
   logic [7:0]  got_crc_lo = 8'h00;
   logic [15:0] quiet_ticks = 16'h0000;

   // Modbus CRC-16, one octet, LSB first
   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] octet);
      logic [15:0] r;
      r = acc ^ {8'h00, octet};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
      return r;
   endfunction

   function automatic int pick_idle(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_result(input logic kind, input logic [7:0] dbyte, input logic [5:0] idx,
                               input logic [1:0] st, input logic [15:0] crx,
                               input logic [15:0] ccalc);
      frame_result_type r;
      r.kind = kind;
      r.data_byte = dbyte;
      r.data_index = idx;
      r.status = st;
      r.dev_addr = got_addr;
      r.func_code = got_func;
      r.data_len = got_len;
      r.crc_received = crx;
      r.crc_calc = ccalc;
      expected_results.push_back(r);
   endtask

   // Advance the frame parser by one accepted word
   task automatic predict_word(input rx_word_type w);
      int p;
      int first_data;
      logic [15:0] crx;
      if (w.op == OP_ARM) begin
         link_state = mode_ack ? LINK_ACK : LINK_READ;
         pos_count = 0;
         frame_size = mode_ack ? 8 : 0;
         crc_acc = CRC_INIT;
         got_addr = 8'h00;
         got_func = 8'h00;
         got_len = mode_ack ? ACK_DATA_LEN : 8'h00;
         got_crc_lo = 8'h00;
         quiet_ticks = 16'h0000;
      end else if (link_state == LINK_IDLE || w.op == OP_UNUSED) begin
         // nothing to do
      end else if (w.op == OP_TICK) begin
         if (int'(quiet_ticks) + 1 >= int'(tick_limit)) begin
            link_state = LINK_IDLE;
            queue_result(KIND_DONE, 8'h00, 6'd0, ST_TIMEOUT, 16'h0000, 16'h0000);
         end else begin
            quiet_ticks = quiet_ticks + 16'd1;
         end
      end else begin
         first_data = (link_state == LINK_ACK) ? 4 : 3;
         quiet_ticks = 16'h0000;
         p = pos_count;
         pos_count = (pos_count + 1) % 512;
         if (p < 2) begin
            if (p == 0) got_addr = w.rx_byte;
            else got_func = w.rx_byte;
            crc_acc = crc16_next(crc_acc, w.rx_byte);
         end else if (link_state == LINK_READ && p == 2) begin
            got_len = w.rx_byte;
            crc_acc = crc16_next(crc_acc, w.rx_byte);
            if (int'(w.rx_byte) >= MaxData) begin
               link_state = LINK_IDLE;
               queue_result(KIND_DONE, 8'h00, 6'd0, ST_OVERFLOW, 16'h0000, 16'h0000);
            end else begin
               frame_size = int'(w.rx_byte) + 5;
            end
         end else if (p + 2 < frame_size) begin
            crc_acc = crc16_next(crc_acc, w.rx_byte);
            if (p >= first_data) begin
               queue_result(KIND_DATA, w.rx_byte, 6'(p - first_data), ST_OK,
                            16'h0000, 16'h0000);
            end
         end else if (p + 2 == frame_size) begin
            got_crc_lo = w.rx_byte;
         end else begin
            crx = {w.rx_byte, got_crc_lo};
            link_state = LINK_IDLE;
            queue_result(KIND_DONE, 8'h00, 6'd0, (crx == crc_acc) ? ST_OK : ST_CRC_ERR,
                         crx, crc_acc);
         end
      end
   endtask

   // Input side: offer queued words, random gaps between them
   rx_word_type offered;
   int          src_idle_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_word(offered);
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (src_idle_left > 0) begin
               src_idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               offered = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= offered.op;
               req_tdata <= offered.rx_byte;
               src_idle_left = pick_idle(src_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: random stalls, compare each word with the oldest expectation
   int               sink_stall_left = 0;
   frame_result_type seen;
   frame_result_type want;

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
         any_fault = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.kind = rsp_tuser;
            seen.data_byte = rsp_tdata[7:0];
            seen.data_index = rsp_tdata[13:8];
            seen.status = rsp_tdata[15:14];
            seen.dev_addr = rsp_tdata[23:16];
            seen.func_code = rsp_tdata[31:24];
            seen.data_len = rsp_tdata[39:32];
            seen.crc_received = rsp_tdata[55:40];
            seen.crc_calc = rsp_tdata[71:56];
            if (expected_results.size() == 0) begin
               $display("%0t: result expected none, got kind %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               any_fault = 1'b1;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 16'(want.kind), 16'(seen.kind));
               check_field("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
               check_field("data_index", 16'(want.data_index), 16'(seen.data_index));
               check_field("status", 16'(want.status), 16'(seen.status));
               check_field("dev_addr", 16'(want.dev_addr), 16'(seen.dev_addr));
               check_field("func_code", 16'(want.func_code), 16'(seen.func_code));
               check_field("data_len", 16'(want.data_len), 16'(seen.data_len));
               check_field("crc_received", want.crc_received, seen.crc_received);
               check_field("crc_calc", want.crc_calc, seen.crc_calc);
            end
         end
         if (sink_stall_left > 0) begin
            sink_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            sink_stall_left = pick_idle(sink_calm);
         end
      end
   end

   task automatic push_word(input logic [1:0] op, input logic [7:0] b);
      rx_word_type w;
      w.op = op;
      w.rx_byte = b;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_word(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // One reply frame: arm, header, data, CRC low then high, with optional damage
   task automatic queue_frame(input logic ack, input logic [7:0] addr, input logic [7:0] func,
                              input int dlen, input frame_flaw_type flaw, input int tick_max);
      logic [7:0] fb[$];
      logic [15:0] acc;
      int n_body;
      int cut;
      int k;
      acc = CRC_INIT;
      fb.push_back(addr);
      fb.push_back(func);
      if (ack) begin
         n_body = 4;
      end else begin
         fb.push_back(8'(dlen));
         n_body = (dlen >= MaxData) ? 0 : dlen;
      end
      for (int i = 0; i < n_body; i++) fb.push_back(8'($urandom_range(0, 255)));
      if (!ack && dlen >= MaxData) begin
         // trailing byte after an overflow is dropped by the block
         fb.push_back(8'($urandom_range(0, 255)));
      end else begin
         foreach (fb[i]) acc = crc16_next(acc, fb[i]);
         fb.push_back(acc[7:0]);
         fb.push_back(acc[15:8]);
         if (flaw == FLAW_CRC) begin
            k = fb.size() - 1 - int'($urandom_range(0, 1));
            fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
         end
      end
      if (flaw == FLAW_CUT || flaw == FLAW_REARM) begin
         cut = $urandom_range(0, fb.size() - 1);
         while (fb.size() > cut) fb.delete(fb.size() - 1);
      end
      push_word(OP_ARM, 8'($urandom_range(0, 255)));
      foreach (fb[i]) begin
         push_word(OP_BYTE, fb[i]);
         if (tick_max > 0 && $urandom_range(0, 99) < 15) push_ticks($urandom_range(1, tick_max));
      end
      if (flaw == FLAW_CUT && tick_limit <= 80) push_ticks((tick_limit == 0) ? 1 : tick_limit);
   endtask

   // Mostly well-formed frames, some damaged, some loose noise
   task automatic queue_random_phase(input int stop_at);
      int pick;
      int r2;
      int dlen;
      int tick_max;
      frame_flaw_type flaw;
      tick_max = (tick_limit > 6) ? 5 : ((tick_limit > 1) ? int'(tick_limit) - 1 : 0);
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         r2 = $urandom_range(0, 99);
         if (r2 < 75) dlen = $urandom_range(0, 8);
         else if (r2 < 95) dlen = $urandom_range(9, 40);
         else dlen = $urandom_range(41, MaxData - 1);
         if (pick >= 93) begin
            repeat ($urandom_range(1, 6))
               push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            flaw = FLAW_NONE;
            if (pick >= 88) flaw = FLAW_REARM;
            else if (pick >= 82) dlen = $urandom_range(MaxData, 255);
            else if (pick >= 72) flaw = FLAW_CUT;
            else if (pick >= 60) flaw = FLAW_CRC;
            queue_frame(mode_ack, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        dlen, flaw, tick_max);
            if ($urandom_range(0, 99) < 10) push_ticks($urandom_range(1, 3));
         end
      end
   endtask

   // Wait until every word went in and every result came out, then let the pipe settle
   task automatic drain_block();
      while (words_accepted != words_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RX_MODE) mode_ack = val[0];
      else tick_limit = val;
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("modbus_rtu_frame_receiver: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic        m;
      logic [15:0] t;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle words, smallest frame, CRC error, rearm, overflow
      push_word(OP_BYTE, 8'hA5);
      push_word(OP_TICK, 8'h00);
      push_word(OP_UNUSED, 8'hFF);
      queue_frame(1'b0, 8'h00, 8'hFF, 0, FLAW_NONE, 0);
      queue_frame(1'b0, 8'hFF, 8'h00, 1, FLAW_CRC, 0);
      push_word(OP_ARM, 8'h00);
      push_word(OP_BYTE, 8'h11);
      queue_frame(1'b0, 8'hFF, 8'h00, MaxData, FLAW_NONE, 0);
      drain_block();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin m = 1'b0; t = 16'hFFFF; end
            1: begin m = 1'b1; t = 16'd1; end
            2: begin m = 1'b0; t = 16'd0; end
            3: begin m = 1'b1; t = 16'hFFFF; end
            4: begin m = 1'b0; t = 16'd3; end
            5: begin m = 1'b1; t = 16'd7; end
            6: begin m = 1'b0; t = 16'($urandom_range(2, 40)); end
            default: begin m = 1'b1; t = 16'($urandom_range(1, 300)); end
         endcase
         src_calm = (ph % 3 == 1);
         sink_calm = (ph % 4 == 2);
         write_reg(CSR_RX_MODE, {15'd0, m});
         write_reg(CSR_TIMEOUT, t);
         // longest legal data field once
         if (ph == 0) queue_frame(1'b0, 8'($urandom_range(0, 255)), 8'h03, MaxData - 1,
                                  FLAW_NONE, 0);
         queue_random_phase(words_queued + PHASE_WORDS);
         drain_block();
      end

      if (any_fault) begin
         $display("modbus_rtu_frame_receiver: mismatch");
      end else begin
         $display("modbus_rtu_frame_receiver: match");
      end
      $finish;
   end

endmodule
